### rtl/bcb_pkg.sv
// bcb_pkg: shared types and constants for the bitfield coverage binner
// no dependencies; imported by bitfield_coverage_binner
package bcb_pkg;

  localparam int CFG_W   = 13;  // piece count register width
  localparam int PIECE_W = 14;  // scaled piece count, doubled up to 2*OUT_BINS-2
  localparam int LEVEL_W = 8;
  localparam int BIN_W   = 6;

  localparam logic       STATUS_OK  = 1'b0;
  localparam logic       STATUS_ERR = 1'b1;
  localparam logic [7:0] LEVEL_ERR  = 8'h00;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CHECK,
    ST_SCALE,
    ST_READ,
    ST_ACC,
    ST_DIV,
    ST_OUT
  } bcb_state_e;

endpackage

### rtl/bitfield_coverage_binner.sv
// bitfield_coverage_binner: loads a piece bitfield into a byte store and resamples it
// depends on bcb_pkg and bcb_ram
//
// Bitfield bytes are taken one beat per cycle while loading into a MAX_BYTES deep byte
// RAM, bit 7 of each byte being the lowest piece. The beat with tlast set starts a run: a
// check state tests the piece count against the byte count (an error run returns a single
// beat with tuser set), a scale state doubles a small piece count up to OUT_BINS and then
// loads the bin bounds, then the sequencer walks every scaled piece index (RAM read
// address, then the registered read data) and, at the end of every bin, runs an 8-step
// shift/subtract divider for count*255/n, n being the pieces in the bin, before offering
// the bin level. The input side is not ready until the last bin beat has been taken.
// piece_count is written through cfg_we_i/cfg_wdata_i; the user must write it only while
// the block is idle, as the block itself does not enforce this.
module bitfield_coverage_binner #(
  parameter int OUT_BINS  = 64,
  parameter int MAX_BYTES = 512
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [bcb_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,  // [7:0] data_byte
  input  logic                      s_axis_tlast,  // last_byte
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [15:0]               m_axis_tdata,  // [7:0] bin_level, [13:8] bin_index
  output logic                      m_axis_tuser,  // status
  output logic                      m_axis_tlast   // last_result
);
  import bcb_pkg::*;

  localparam int CW   = $clog2(MAX_BYTES + 1);
  localparam int AW   = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int PW   = PIECE_W;
  localparam int ACCW = PW + 7;
  localparam int RW   = PW + 9;
  localparam int BW   = ((CW + 3) > PW ? (CW + 3) : PW) + 1;

  bcb_state_e state_q, state_d;

  logic [CFG_W-1:0]   pc_q;
  logic [CW-1:0]      count_q, count_d;
  logic               ovf_q, ovf_d;
  logic [PW-1:0]      p_q, p_d;
  logic [2:0]         shift_q, shift_d;
  logic [PW-1:0]      j_q, j_d;
  logic [ACCW-1:0]    jb_q, jb_d;   // (j+2)*OUT_BINS
  logic [ACCW-1:0]    ip_q, ip_d;   // (bin+1)*P
  logic [BIN_W-1:0]   bin_q, bin_d;
  logic [PW-1:0]      set_q, set_d;
  logic [PW-1:0]      n_q, n_d;
  logic [RW-1:0]      rem_q, rem_d;
  logic [2:0]         k_q, k_d;
  logic [LEVEL_W-1:0] level_q, level_d;
  logic               status_q, status_d;
  logic               last_q, last_d;

  logic          in_beat, out_beat, ram_we, run_ok, bin_end, last_bin, cur_bit;
  logic [BW-1:0] bits_w, pc_w;
  logic [PW-1:0] idx, set_new, n_new;
  logic [RW-1:0] den_sh;
  logic [AW-1:0] raddr, waddr;
  logic [7:0]    rdata;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_beat = m_axis_tvalid && m_axis_tready;
  assign ram_we   = in_beat && (count_q < CW'(MAX_BYTES));
  assign waddr    = AW'(count_q);

  assign bits_w = BW'({count_q, 3'b000});
  assign pc_w   = BW'(pc_q);
  assign run_ok = !ovf_q && (pc_q != '0) && ((pc_w + BW'(8)) > bits_w) && (pc_w <= bits_w);

  assign idx     = j_q >> shift_q;
  assign raddr   = AW'(idx >> 3);
  assign cur_bit = rdata[3'd7 - idx[2:0]];
  assign set_new = set_q + PW'(cur_bit);
  assign n_new   = n_q + PW'(1);
  assign bin_end = jb_q > ip_q;
  assign last_bin = bin_q == BIN_W'(OUT_BINS - 1);
  assign den_sh  = RW'(n_q) << k_q;

  bcb_ram #(
    .WIDTH (8),
    .DEPTH (MAX_BYTES),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (s_axis_tdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:  if (in_beat && s_axis_tlast) state_d = ST_CHECK;
      ST_CHECK: state_d = run_ok ? ST_SCALE : ST_OUT;
      ST_SCALE: if (p_q >= PW'(OUT_BINS)) state_d = ST_READ;
      ST_READ:  state_d = ST_ACC;
      ST_ACC:   state_d = bin_end ? ST_DIV : ST_READ;
      ST_DIV:   if (k_q == 3'd0) state_d = ST_OUT;
      ST_OUT: begin
        if (out_beat) state_d = last_q ? ST_LOAD : ST_READ;
      end
      default:  state_d = ST_LOAD;
    endcase
  end

  // datapath
  always_comb begin
    count_d  = count_q;
    ovf_d    = ovf_q;
    p_d      = p_q;
    shift_d  = shift_q;
    j_d      = j_q;
    jb_d     = jb_q;
    ip_d     = ip_q;
    bin_d    = bin_q;
    set_d    = set_q;
    n_d      = n_q;
    rem_d    = rem_q;
    k_d      = k_q;
    level_d  = level_q;
    status_d = status_q;
    last_d   = last_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_beat) begin
          if (ram_we) count_d = count_q + CW'(1);
          else        ovf_d   = 1'b1;
        end
      end
      ST_CHECK: begin
        count_d  = '0;
        ovf_d    = 1'b0;
        p_d      = PW'(pc_q);
        shift_d  = '0;
        j_d      = '0;
        bin_d    = '0;
        set_d    = '0;
        n_d      = '0;
        level_d  = LEVEL_ERR;
        status_d = STATUS_ERR;
        last_d   = 1'b1;
      end
      ST_SCALE: begin
        if (p_q < PW'(OUT_BINS)) begin
          p_d     = p_q << 1;
          shift_d = shift_q + 3'd1;
        end else begin
          ip_d = ACCW'(p_q);
          jb_d = ACCW'(2 * OUT_BINS);
        end
      end
      ST_ACC: begin
        set_d = set_new;
        n_d   = n_new;
        j_d   = j_q + PW'(1);
        jb_d  = jb_q + ACCW'(OUT_BINS);
        if (bin_end) begin
          // count*255 as count*256 - count
          rem_d   = (RW'(set_new) << 8) - RW'(set_new);
          k_d     = 3'd7;
          level_d = '0;
        end
      end
      ST_DIV: begin
        if (rem_q >= den_sh) begin
          rem_d      = rem_q - den_sh;
          level_d[k_q] = 1'b1;
        end
        k_d      = k_q - 3'd1;
        status_d = STATUS_OK;
        last_d   = last_bin;
      end
      ST_OUT: begin
        if (out_beat && !last_q) begin
          set_d = '0;
          n_d   = '0;
          bin_d = bin_q + BIN_W'(1);
          ip_d  = ip_q + ACCW'(p_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      pc_q    <= CFG_W'(1);
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      if (cfg_we_i) pc_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q      <= p_d;
    shift_q  <= shift_d;
    j_q      <= j_d;
    jb_q     <= jb_d;
    ip_q     <= ip_d;
    bin_q    <= bin_d;
    set_q    <= set_d;
    n_q      <= n_d;
    rem_q    <= rem_d;
    k_q      <= k_d;
    level_q  <= level_d;
    status_q <= status_d;
    last_q   <= last_d;
  end

  assign s_axis_tready = (state_q == ST_LOAD);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = {2'b00, (status_q == STATUS_ERR) ? BIN_W'(0) : bin_q, level_q};
  assign m_axis_tuser  = status_q;
  assign m_axis_tlast  = last_q;

endmodule

### rtl/bcb_ram.sv
// bcb_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module bcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### tb/bitfield_coverage_binner_tb.sv
// bitfield_coverage_binner_tb: self-checking testbench for the bitfield coverage binner
// depends on bcb_pkg and bitfield_coverage_binner (with bcb_ram); reads no files
// a directed table, then random runs, checked beat by beat against a resampling predictor
`timescale 1ns / 100ps

module bitfield_coverage_binner_tb;
  import bcb_pkg::*;

  localparam int OUT_BINS     = 64;
  localparam int MAX_BYTES    = 512;
  localparam int RANDOM_ITEMS = 195;
  localparam int LONG_HOLD    = 400;
  localparam int MAX_REPORTS  = 30;

  typedef enum logic [1:0] {
    RUN_PREDICT,
    RUN_FLAT,
    RUN_ERROR
  } run_kind_e;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [BIN_W-1:0]   index;
    logic               status;
    logic               last;
  } bin_beat_t;

  typedef struct packed {
    run_kind_e          kind;
    logic [LEVEL_W-1:0] level;
  } run_check_t;

  typedef struct packed {
    logic               cfg_we;
    logic [CFG_W-1:0]   cfg_val;
    logic [7:0]         data;
    logic               last;
    run_kind_e          kind;
    logic [LEVEL_W-1:0] level;
  } stim_row_t;

  // directed runs: expected beats typed in where they are obvious
  localparam stim_row_t DIRECTED_ROWS [25] = '{
    '{1'b0, 13'd0,    8'h80, 1'b1, RUN_FLAT,    8'd255},  // reset count of one, bit set
    '{1'b0, 13'd0,    8'h7F, 1'b1, RUN_FLAT,    8'd0},    // reset count of one, bit clear
    '{1'b1, 13'd8,    8'hFF, 1'b1, RUN_FLAT,    8'd255},
    '{1'b0, 13'd0,    8'h00, 1'b1, RUN_FLAT,    8'd0},
    '{1'b0, 13'd0,    8'hA5, 1'b1, RUN_PREDICT, 8'd0},
    '{1'b1, 13'd9,    8'hC3, 1'b1, RUN_ERROR,   8'd0},    // one byte short
    '{1'b0, 13'd0,    8'h3C, 1'b0, RUN_PREDICT, 8'd0},
    '{1'b0, 13'd0,    8'h80, 1'b1, RUN_PREDICT, 8'd0},
    '{1'b1, 13'd0,    8'hFF, 1'b1, RUN_ERROR,   8'd0},    // zero piece count
    '{1'b1, 13'd64,   8'hFF, 1'b0, RUN_PREDICT, 8'd0},
    '{1'b0, 13'd0,    8'h00, 1'b0, RUN_PREDICT, 8'd0},
    '{1'b0, 13'd0,    8'hF0, 1'b0, RUN_PREDICT, 8'd0},
    '{1'b0, 13'd0,    8'h0F, 1'b0, RUN_PREDICT, 8'd0},
    '{1'b0, 13'd0,    8'hAA, 1'b0, RUN_PREDICT, 8'd0},
    '{1'b0, 13'd0,    8'h55, 1'b0, RUN_PREDICT, 8'd0},
    '{1'b0, 13'd0,    8'h01, 1'b0, RUN_PREDICT, 8'd0},
    '{1'b0, 13'd0,    8'h80, 1'b1, RUN_PREDICT, 8'd0},
    '{1'b1, 13'd17,   8'hFF, 1'b0, RUN_PREDICT, 8'd0},
    '{1'b0, 13'd0,    8'hFF, 1'b1, RUN_ERROR,   8'd0},    // count above bytes*8
    '{1'b0, 13'd0,    8'h12, 1'b0, RUN_PREDICT, 8'd0},
    '{1'b0, 13'd0,    8'h34, 1'b0, RUN_PREDICT, 8'd0},
    '{1'b0, 13'd0,    8'hC0, 1'b1, RUN_PREDICT, 8'd0},
    '{1'b1, 13'd8,    8'hFF, 1'b0, RUN_PREDICT, 8'd0},
    '{1'b0, 13'd0,    8'hFF, 1'b1, RUN_ERROR,   8'd0},    // one byte too many
    '{1'b1, 13'd8191, 8'h00, 1'b1, RUN_ERROR,   8'd0}     // largest register value
  };

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CFG_W-1:0]   cfg_wdata_i;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata;
  logic               s_axis_tlast;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [15:0]        m_axis_tdata;
  logic               m_axis_tuser;
  logic               m_axis_tlast;

  // shadow of the block's state
  logic [7:0]         loaded_bytes [MAX_BYTES];
  int unsigned        loaded_count;
  bit                 store_overflow;
  int unsigned        piece_count;

  bin_beat_t          bin_beats_q [$];
  run_check_t         run_check_q [$];

  int unsigned        tx_idle_pct;
  int unsigned        rx_idle_pct;
  bit                 hold_req;
  int unsigned        holds_done;
  int unsigned        beats_checked;
  int unsigned        mismatches;
  int unsigned        good_runs;
  int unsigned        error_runs;
  bit                 failed;

  bitfield_coverage_binner #(
    .OUT_BINS  (OUT_BINS),
    .MAX_BYTES (MAX_BYTES)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return 1;
    if (r < 95) return $urandom_range(2, 4);
    return $urandom_range(10, 40);
  endfunction

  // resample the loaded bitfield into bins, pushing the expected beats
  task automatic resample_bitfield();
    int unsigned bits, p, shift, lo, hi, set_cnt, n, idx;
    bin_beat_t   beat;
    bits = loaded_count * 8;
    if (store_overflow || piece_count == 0 || piece_count + 8 <= bits
        || piece_count > bits) begin
      bin_beats_q.push_back('{LEVEL_ERR, '0, STATUS_ERR, 1'b1});
      error_runs++;
    end else begin
      p = piece_count;
      shift = 0;
      while (p < OUT_BINS) begin
        p = p << 1;
        shift++;
      end
      for (int i = 0; i < OUT_BINS; i++) begin
        lo = i * p / OUT_BINS;
        hi = (i + 1) * p / OUT_BINS;
        if (hi == lo) hi++;
        set_cnt = 0;
        n = 0;
        for (; lo < hi; lo++) begin
          idx = lo >> shift;
          set_cnt += loaded_bytes[idx >> 3][7 - (idx & 7)];
          n++;
        end
        beat.level  = LEVEL_W'(set_cnt * 255 / n);
        beat.index  = BIN_W'(i);
        beat.status = STATUS_OK;
        beat.last   = (i == OUT_BINS - 1);
        bin_beats_q.push_back(beat);
      end
      good_runs++;
    end
  endtask

  task automatic take_byte(input logic [7:0] data, input logic last);
    run_check_t chk;
    if (loaded_count < MAX_BYTES) begin
      loaded_bytes[loaded_count] = data;
      loaded_count++;
    end else begin
      store_overflow = 1'b1;
    end
    if (last) begin
      chk = run_check_q.pop_front();
      case (chk.kind)
        RUN_FLAT: begin
          for (int i = 0; i < OUT_BINS; i++)
            bin_beats_q.push_back('{chk.level, BIN_W'(i), STATUS_OK, i == OUT_BINS - 1});
          good_runs++;
        end
        RUN_ERROR: begin
          bin_beats_q.push_back('{LEVEL_ERR, '0, STATUS_ERR, 1'b1});
          error_runs++;
        end
        default: resample_bitfield();
      endcase
      loaded_count   = 0;
      store_overflow = 1'b0;
    end
  endtask

  // both handshakes are sampled here at the edge, before the block updates
  always @(posedge clk_i) begin : beat_monitor
    bin_beat_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[7:0], m_axis_tdata[13:8], m_axis_tuser, m_axis_tlast};
        if (bin_beats_q.size() == 0) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected bin beat level %0d index %0d status %0d last %0d",
                     $time, got.level, got.index, got.status, got.last);
        end else begin
          want = bin_beats_q.pop_front();
          beats_checked++;
          if (got !== want) begin
            failed = 1'b1;
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: level/index/status/last expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                       $time, want.level, want.index, want.status, want.last,
                       got.level, got.index, got.status, got.last);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) take_byte(s_axis_tdata, s_axis_tlast);
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_req = 1'b0;
        holds_done++;
      end else if ($urandom_range(0, 99) < rx_idle_pct) begin
        m_axis_tready <= 1'b0;
        repeat (idle_len()) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_beat(input logic [7:0] data, input logic last);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat (idle_len()) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // drop valid and let every expected beat drain before touching the register
  task automatic write_piece_count(input logic [CFG_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (bin_beats_q.size() != 0 || run_check_q.size() != 0);
    repeat (8) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    piece_count = value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic send_run(input int unsigned n_bytes);
    int unsigned fill;
    logic [7:0]  data;
    fill = $urandom_range(0, 5);
    run_check_q.push_back('{RUN_PREDICT, 8'd0});
    for (int unsigned k = 0; k < n_bytes; k++) begin
      case (fill)
        0:       data = 8'hFF;
        1:       data = 8'h00;
        2:       data = 8'($urandom) & 8'($urandom);
        3:       data = 8'($urandom) | 8'($urandom);
        default: data = 8'($urandom);
      endcase
      send_beat(data, k == n_bytes - 1);
    end
  endtask

  initial begin
    int unsigned rand_items, runs, n, r, pc;
    bit          first_phase;
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_wdata_i    <= '0;
    s_axis_tvalid  <= 1'b0;
    s_axis_tdata   <= '0;
    s_axis_tlast   <= 1'b0;
    loaded_count   = 0;
    store_overflow = 1'b0;
    piece_count    = 1;
    hold_req       = 1'b0;
    holds_done     = 0;
    beats_checked  = 0;
    mismatches     = 0;
    good_runs      = 0;
    error_runs     = 0;
    failed         = 1'b0;
    tx_idle_pct    = 30;
    rx_idle_pct    = 30;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_ROWS[k]) begin
      if (DIRECTED_ROWS[k].cfg_we) write_piece_count(DIRECTED_ROWS[k].cfg_val);
      if (DIRECTED_ROWS[k].last)
        run_check_q.push_back('{DIRECTED_ROWS[k].kind, DIRECTED_ROWS[k].level});
      send_beat(DIRECTED_ROWS[k].data, DIRECTED_ROWS[k].last);
    end

    rand_items  = 0;
    first_phase = 1'b1;
    while (rand_items < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (first_phase)  pc = $urandom_range(9, 64);
      else if (r < 70)  pc = $urandom_range(1, 64);
      else if (r < 95)  pc = $urandom_range(65, 256);
      else              pc = $urandom_range(257, 1024);
      write_piece_count(CFG_W'(pc));
      tx_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
      rx_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
      runs = first_phase ? 3 : $urandom_range(1, 3);
      // receiver stalls while the next runs keep being offered
      if (first_phase) hold_req = 1'b1;
      first_phase = 1'b0;
      for (int j = 0; j < runs; j++) begin
        n = (pc + 7) / 8;
        r = $urandom_range(0, 99);
        if (r < 8) n = n + 1;
        else if (r < 15 && n > 1) n = n - 1;
        send_run(n);
        rand_items += n;
      end
    end
    s_axis_tvalid <= 1'b0;

    do @(posedge clk_i); while (bin_beats_q.size() != 0 || run_check_q.size() != 0);
    repeat (40) @(posedge clk_i);
    if (bin_beats_q.size() != 0) failed = 1'b1;

    $display("covered %0d resampled runs and %0d rejected runs, %0d bin beats checked",
             good_runs, error_runs, beats_checked);
    $display("piece counts 0 to 8191, %0d long receiver hold(s), %0d mismatches",
             holds_done, mismatches);
    if (!failed) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("timeout waiting for bin beats");
    $display("Verification failed");
    $finish;
  end

endmodule
